@@ src/crc16fb_pkg.sv @@
// Shared constants, types and the CRC-16/CCITT-FALSE byte update.
package crc16fb_pkg;

  localparam logic [7:0]  StartByte     = 8'h24;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'h1021;
  localparam logic [7:0]  DevCodeReset  = 8'h01;
  localparam logic        LinkUpReset   = 1'b1;

  localparam int unsigned GrpDepth = 3;
  localparam int unsigned GrpIdxW  = $clog2(GrpDepth);

  // configuration register indexes
  typedef enum logic {
    CFG_DEVICE_CODE = 1'b0,
    CFG_LINK_UP     = 1'b1
  } cfg_idx_e;

  // group of results caused by one input byte
  typedef struct packed {
    logic                          vld;
    logic                          three;      // 3 results, else 1
    logic                          frame_end;  // last of the group closes the frame
    logic [GrpDepth-1:0][7:0]      bytes;      // bytes[0] goes out first
  } grp_t;

  function automatic logic [15:0] crc_upd(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ b[i]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/crc16fb_if.sv @@
// Stream interfaces for the input bytes and the frame bytes.
interface crc16fb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface crc16fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

@@ src/crc16_frame_builder_top.sv @@
// Top level of the CRC-16 frame builder.
//
// Input channel in_if carries one message byte per transaction: a command,
// a length, then that many payload bytes. Output channel out_if carries the
// frame: 0x24, device code, command, length, payload, CRC high, CRC low
// (CRC-16/CCITT-FALSE over command, length and payload). run_last marks the
// last byte caused by one input byte, frame_end marks the CRC low byte.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 = device code, 1 = link up) at the clock edge.
// Latency: the first result byte is valid the cycle after its input is
// taken. An input byte yields one or three result bytes; the group register
// drains one byte per cycle while the receiver is ready, so single-byte items
// flow at one per cycle and command and CRC-tail items hold the input until their last byte is taken.
// When link up is low, bytes are still taken and parsed and nothing is sent.
// Reset clears the parser to expect a command, seeds the CRC with 0xFFFF,
// sets device code 1 and link up. A stalled receiver holds the current byte
// and the input is refused once the group register cannot be refilled.
module crc16_frame_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  crc16fb_in_if.sink  in_if,
  crc16fb_out_if.source out_if
);
  import crc16fb_pkg::*;

  logic [7:0] dev_code_q;
  logic       link_up_q;
  logic       free;
  logic       accept;
  grp_t       grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_code_q <= DevCodeReset;
      link_up_q  <= LinkUpReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEVICE_CODE: dev_code_q <= cfg_wdata_i;
        CFG_LINK_UP:     link_up_q  <= cfg_wdata_i[0];
        default:         ;
      endcase
    end
  end

  assign in_if.ready = free;
  assign accept      = in_if.valid & free;

  crc16fb_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_i     (in_if.data_byte),
    .dev_code_i (dev_code_q),
    .link_up_i  (link_up_q),
    .grp_o      (grp)
  );

  crc16fb_serializer u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .grp_i  (grp),
    .free_o (free),
    .out_if (out_if)
  );

endmodule

@@ src/crc16fb_parser.sv @@
// Message parser: tracks command/length/payload, runs the CRC, builds result groups.
module crc16fb_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          dev_code_i,
  input  logic                link_up_i,
  output crc16fb_pkg::grp_t   grp_o
);
  import crc16fb_pkg::*;

  localparam logic [1:0] PH_CMD = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_run;
  logic [7:0]  left_dec;
  grp_t        grp;

  assign crc_run  = crc_upd(crc_q, data_i);
  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d         = phase_q;
    left_d          = left_q;
    crc_d           = crc_run;
    grp.vld         = accept_i & link_up_i;
    grp.three       = 1'b0;
    grp.frame_end   = 1'b0;
    grp.bytes[0]    = data_i;
    grp.bytes[1]    = crc_run[15:8];
    grp.bytes[2]    = crc_run[7:0];
    case (phase_q)
      PH_LEN: begin
        grp.three     = (data_i == 8'd0);
        grp.frame_end = (data_i == 8'd0);
        left_d        = data_i;
        phase_d       = (data_i == 8'd0) ? PH_CMD : PH_PAY;
      end
      PH_PAY: begin
        grp.three     = (left_dec == 8'd0);
        grp.frame_end = (left_dec == 8'd0);
        left_d        = left_dec;
        phase_d       = (left_dec == 8'd0) ? PH_CMD : PH_PAY;
      end
      default: begin
        // command byte; the unused phase code lands here too
        crc_d         = crc_upd(CrcInit, data_i);
        grp.three     = 1'b1;
        grp.bytes[0]  = StartByte;
        grp.bytes[1]  = dev_code_i;
        grp.bytes[2]  = data_i;
        left_d        = 8'd0;
        phase_d       = PH_LEN;
      end
    endcase
  end

  assign grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      left_q  <= 8'd0;
      crc_q   <= CrcInit;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
    end
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("parser phase left the legal range");

  a_cmd_to_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_CMD |=> phase_q == PH_LEN)
    else $error("command byte did not advance to length");

  a_pay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> left_q != 8'd0)
    else $error("payload phase with no bytes left");

endmodule

@@ src/crc16fb_serializer.sv @@
// Result group register and byte serializer toward the output channel.
module crc16fb_serializer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crc16fb_pkg::grp_t     grp_i,
  output logic                  free_o,
  crc16fb_out_if.source         out_if
);
  import crc16fb_pkg::*;

  localparam logic [GrpIdxW-1:0] LastIdx = GrpIdxW'(GrpDepth - 1);

  logic                      vld_q;
  logic [GrpIdxW-1:0]        idx_q;
  logic                      three_q;
  logic                      fe_q;
  logic [GrpDepth-1:0][7:0]  bytes_q;
  logic                      last;
  logic                      pop;

  assign last   = three_q ? (idx_q == LastIdx) : 1'b1;
  assign pop    = vld_q & out_if.ready;
  assign free_o = ~vld_q | (out_if.ready & last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (grp_i.vld) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (pop && last) begin
      vld_q <= 1'b0;
    end else if (pop) begin
      idx_q <= idx_q + GrpIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_i.vld) begin
      three_q <= grp_i.three;
      fe_q    <= grp_i.frame_end;
      bytes_q <= grp_i.bytes;
    end
  end

  always_comb begin
    case (idx_q)
      GrpIdxW'(0): out_if.out_byte = bytes_q[0];
      GrpIdxW'(1): out_if.out_byte = bytes_q[1];
      default:     out_if.out_byte = bytes_q[2];
    endcase
  end

  assign out_if.valid     = vld_q;
  assign out_if.run_last  = last;
  assign out_if.frame_end = fe_q & last;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_i.vld |-> free_o) else $error("group loaded over a pending group");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (idx_q <= LastIdx) && (three_q || idx_q == '0))
    else $error("serializer index beyond its group");

  a_end_needs_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && out_if.frame_end |-> three_q && idx_q == LastIdx)
    else $error("frame end outside a CRC tail");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !out_if.ready |=> vld_q && $stable(idx_q))
    else $error("serializer advanced while stalled");

endmodule

@@ test/crc16_frame_builder_top_test.sv @@
// Self-checking testbench for the CRC-16 frame builder: directed and random byte streams.
module crc16_frame_builder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16fb_pkg::*;

  localparam int unsigned HoldCycles = 80;    // long receiver hold-off
  localparam int unsigned QuietLimit = 1000;  // cycles without any transaction

  typedef enum logic [1:0] {
    EXP_CMD     = 2'd0,
    EXP_LEN     = 2'd1,
    EXP_PAYLOAD = 2'd2
  } parse_e;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } frame_byte_t;

  logic       clk;
  logic       rst_ni;
  logic       cfg_we;
  cfg_idx_e   cfg_idx;
  logic [7:0] cfg_wdata;

  crc16fb_in_if  in_ch ();
  crc16fb_out_if out_ch ();

  crc16_frame_builder_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // frame predictor state
  parse_e      pars_phase = EXP_CMD;
  logic [7:0]  pay_left   = 8'd0;
  logic [15:0] run_crc    = CrcInit;
  logic [7:0]  dev_code   = DevCodeReset;
  logic        link_on    = LinkUpReset;
  frame_byte_t frame_q[$];

  int unsigned in_cnt      = 0;
  int unsigned out_cnt     = 0;
  int unsigned frames_done = 0;
  int unsigned err_cnt     = 0;
  int unsigned quiet       = 0;

  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_req  = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // CCITT-FALSE update, byte folded into the top of the register
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ CrcPoly) : (r << 1);
    return r;
  endfunction

  task automatic predict_frame_bytes(input logic [7:0] d);
    frame_byte_t grp[3];
    int          n;
    n = 0;
    case (pars_phase)
      EXP_LEN: begin
        run_crc = crc_next(run_crc, d);
        grp[0]  = '{d, 1'b0, 1'b0};
        n       = 1;
        if (d == 8'd0) begin
          grp[1]     = '{run_crc[15:8], 1'b0, 1'b0};
          grp[2]     = '{run_crc[7:0], 1'b0, 1'b1};
          n          = 3;
          pars_phase = EXP_CMD;
        end else begin
          pay_left   = d;
          pars_phase = EXP_PAYLOAD;
        end
      end
      EXP_PAYLOAD: begin
        run_crc  = crc_next(run_crc, d);
        grp[0]   = '{d, 1'b0, 1'b0};
        n        = 1;
        pay_left = pay_left - 8'd1;
        if (pay_left == 8'd0) begin
          grp[1]     = '{run_crc[15:8], 1'b0, 1'b0};
          grp[2]     = '{run_crc[7:0], 1'b0, 1'b1};
          n          = 3;
          pars_phase = EXP_CMD;
        end
      end
      default: begin
        // unused phase code falls back to expecting a command
        run_crc    = crc_next(CrcInit, d);
        grp[0]     = '{StartByte, 1'b0, 1'b0};
        grp[1]     = '{dev_code, 1'b0, 1'b0};
        grp[2]     = '{d, 1'b0, 1'b0};
        n          = 3;
        pay_left   = 8'd0;
        pars_phase = EXP_LEN;
      end
    endcase
    // link down: parser and CRC advance, nothing goes out
    if (link_on) begin
      grp[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) frame_q.push_back(grp[i]);
    end
  endtask

  task automatic report_field(input string fld, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= 30)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fld, want, got);
    end
  endtask

  task automatic check_frame_byte();
    frame_byte_t want;
    if (frame_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 30)
        $display("%0t: unexpected frame byte: expected none, actual %02h last=%0b end=%0b",
                 $time, out_ch.out_byte, out_ch.run_last, out_ch.frame_end);
    end else begin
      want = frame_q.pop_front();
      report_field("out_byte", want.data, out_ch.out_byte);
      report_field("run_last", want.run_last, out_ch.run_last);
      report_field("frame_end", want.frame_end, out_ch.frame_end);
    end
    out_cnt++;
    if (out_ch.frame_end) frames_done++;
  endtask

  // sampled at the edge, before any of this edge's updates land
  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) check_frame_byte();
      if (in_ch.valid && in_ch.ready) begin
        predict_frame_bytes(in_ch.data_byte);
        in_cnt++;
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_DEVICE_CODE) dev_code = cfg_wdata;
        else link_on = cfg_wdata[0];
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) quiet = 0;
      else quiet++;
    end
  end

  initial begin
    while (quiet < QuietLimit) @(posedge clk);
    $display("%0t: watchdog expired, %0d frame bytes still expected", $time, frame_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len);
    send_byte(cmd);
    send_byte(len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // wait until every predicted byte is out and the group register is empty;
  // the first wait lets the last accepted byte be predicted before the queue is checked
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(9, 40));
    return 8'($urandom_range(0, 8));
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // link drops part way through a frame and comes back before its end or after it
  task automatic link_glitch();
    int n;
    int k;
    int j;
    n = $urandom_range(1, 6);
    k = $urandom_range(0, n);
    j = $urandom_range(0, n - k);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'(n));
    repeat (k) send_byte(8'($urandom_range(0, 255)));
    write_reg(CFG_LINK_UP, 8'd0);
    repeat (j) send_byte(8'($urandom_range(0, 255)));
    write_reg(CFG_LINK_UP, 8'd1);
    repeat (n - k - j) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_reset_values();
    send_frame(8'h01, 8'd0);
    send_frame(8'hC3, 8'd3);
  endtask

  task automatic test_field_extremes();
    write_reg(CFG_DEVICE_CODE, 8'h00);
    send_byte(8'hFF);
    send_byte(8'd6);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h80);
    send_byte(8'h01);
    write_reg(CFG_DEVICE_CODE, 8'hFF);
    send_frame(8'h00, 8'd0);
    send_frame(8'h80, 8'd1);
  endtask

  task automatic test_link_down();
    write_reg(CFG_LINK_UP, 8'd0);
    send_frame(8'h5A, 8'd3);
    send_frame(8'h00, 8'd0);
    write_reg(CFG_LINK_UP, 8'd1);
    send_frame(8'hA5, 8'd2);
    // partial frame: middle payload byte dropped, CRC tail still sent
    send_byte(8'h33);
    send_byte(8'd4);
    send_byte(8'h11);
    send_byte(8'h22);
    write_reg(CFG_LINK_UP, 8'd0);
    send_byte(8'h44);
    write_reg(CFG_LINK_UP, 8'd1);
    send_byte(8'h66);
  endtask

  // longest length the length byte can carry
  task automatic test_full_length();
    write_reg(CFG_DEVICE_CODE, 8'h7E);
    send_frame(8'($urandom_range(0, 255)), 8'd255);
  endtask

  task automatic test_backpressure();
    settle();
    hold_req = 1'b1;
    repeat (3) send_frame(8'($urandom_range(0, 255)), 8'd4);
    send_frame(8'($urandom_range(0, 255)), 8'd0);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = in_cnt + 30;
    while (in_cnt < stop_at) begin
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_DEVICE_CODE, pick_code());
        1:       link_glitch();
        default: send_frame(8'($urandom_range(0, 255)), pick_len());
      endcase
    end
  endtask

  task automatic test_steady_stream();
    int unsigned stop_at;
    settle();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(CFG_DEVICE_CODE, pick_code());
    stop_at = in_cnt + 20;
    while (in_cnt < stop_at) send_frame(8'($urandom_range(0, 255)), pick_len());
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_DEVICE_CODE;
    cfg_wdata       <= 8'h00;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_field_extremes();
    test_link_down();
    test_full_length();
    test_backpressure();
    test_random_frames();
    test_steady_stream();

    settle();
    repeat (8) @(posedge clk);

    $display("Run: %0d input bytes, %0d frame bytes checked, %0d frames closed.",
             in_cnt, out_cnt, frames_done);
    $display("Covered device codes 00/01/FF, link drops mid-frame, lengths 0..255, hold-off.");
    if (err_cnt == 0 && frame_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
